@@ hw/rtl/tcpt_pkg.sv @@
// Shared types and constants for the TCP connection phase tracker.
// Holds the request and response structs, the phase and event codes
// and the internal command struct. Depends on nothing.
package tcpt_pkg;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [1:0] DIR_UNKNOWN = 2'd0;
   localparam logic [1:0] DIR_A_TO_B  = 2'd1;
   localparam logic [1:0] DIR_B_TO_A  = 2'd2;

   localparam int FLAG_FIN_BIT = 0;
   localparam int FLAG_SYN_BIT = 1;
   localparam int FLAG_RST_BIT = 2;
   localparam int FLAG_ACK_BIT = 4;

   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_DIR = 1'b1;

   typedef enum logic [3:0] {
      PH_UNOBSERVED  = 4'd0,
      PH_SYN         = 4'd1,
      PH_SYNACK      = 4'd2,
      PH_ESTABLISHED = 4'd3,
      PH_MIDSTREAM   = 4'd4,
      PH_FIN         = 4'd5,
      PH_FIN_BOTH    = 4'd6,
      PH_CLOSED      = 4'd7,
      PH_RESET       = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      EV_OTHER  = 3'd0,
      EV_SYN    = 3'd1,
      EV_SYNACK = 3'd2,
      EV_ACK    = 3'd3,
      EV_FIN    = 3'd4,
      EV_RST    = 3'd5
   } event_type;

   typedef struct packed {
      logic       func;
      logic [1:0] direction;
      logic [8:0] flag_bits;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [3:0] phase;
      logic       handshake_done;
      logic [1:0] initiator;
      logic [1:0] first_fin_side;
   } rsp_type;

   typedef struct packed {
      logic       restart;
      logic       bad_dir;
      logic [1:0] dir;
      event_type  ev;
   } cmd_type;

endpackage

@@ hw/rtl/tcp_connection_phase_tracker.sv @@
// Top level of the TCP connection phase tracker.
// Instantiates tcpt_front, tcpt_cmd_fifo and tcpt_back; uses tcpt_pkg.
//
//   Channel    Ports                            Moves
//   request    req_push, req_full, req_data     func, direction, flag_bits
//   response   rsp_pop, rsp_empty, rsp_data     status, phase, flags, sides
//
// One request per cycle is sustained while the response side keeps up;
// each request is registered in the command queue, and the phase engine
// updates the state and queues the response when it takes the command.
// Reset is synchronous and empties both queues; the state returns to
// unobserved.
// A stalled response side fills the two-entry response queue, then the
// two-entry command queue, and only then raises req_full.
module tcp_connection_phase_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tcpt_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tcpt_pkg::rsp_type rsp_data
);
   import tcpt_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    cmd_empty;
   logic    cmd_pop;

   tcpt_front u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   tcpt_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (head_cmd)
   );

   tcpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> ##1 !rsp_empty)
      else $error("accepted request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.handshake_done) |->
         ((rsp_data.phase != PH_UNOBSERVED) && (rsp_data.phase != PH_SYN) &&
          (rsp_data.phase != PH_SYNACK)))
      else $error("handshake flagged done during the opening phases");

endmodule

@@ hw/rtl/tcpt_front.sv @@
// Front end of the phase tracker: checks the direction and classifies
// the TCP flags of each request into a command. Uses tcpt_pkg.
module tcpt_front (
   input  tcpt_pkg::req_type req,
   output tcpt_pkg::cmd_type cmd
);
   import tcpt_pkg::*;

   event_type ev;

   always_comb begin
      priority if (req.flag_bits[FLAG_RST_BIT]) begin
         ev = EV_RST;
      end else if (req.flag_bits[FLAG_FIN_BIT]) begin
         ev = EV_FIN;
      end else if (req.flag_bits[FLAG_SYN_BIT] && req.flag_bits[FLAG_ACK_BIT]) begin
         ev = EV_SYNACK;
      end else if (req.flag_bits[FLAG_SYN_BIT]) begin
         ev = EV_SYN;
      end else if (req.flag_bits[FLAG_ACK_BIT]) begin
         ev = EV_ACK;
      end else begin
         ev = EV_OTHER;
      end
   end

   always_comb begin
      cmd.restart = (req.func == FUNC_RESTART);
      cmd.bad_dir = !((req.direction == DIR_A_TO_B) || (req.direction == DIR_B_TO_A));
      cmd.dir     = req.direction;
      cmd.ev      = ev;
   end

endmodule

@@ hw/rtl/tcpt_cmd_fifo.sv @@
// Short command queue between the front end and the phase engine.
// Accepts a push and a pop in the same cycle. Uses tcpt_pkg.
module tcpt_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcpt_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tcpt_pkg::cmd_type pop_data
);
   import tcpt_pkg::*;

   cmd_type               mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]  count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/tcpt_back.sv @@
// Phase engine of the tracker: applies one command per cycle, when the response
// queue has room, to the connection state and queues the responses. Uses tcpt_pkg.
module tcpt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  tcpt_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tcpt_pkg::rsp_type rsp_data
);
   import tcpt_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [1:0]            init_ff, init_in;
   logic [1:0]            fin_ff, fin_in;
   logic                  hs_ff, hs_in;
   logic                  status;
   rsp_type               rsp_new;

   rsp_type               mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic                  rsp_full;
   logic                  take;
   logic                  do_pop;

   assign rsp_full  = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign take      = !cmd_empty && (!rsp_full || do_pop);
   assign cmd_pop   = take;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      phase_in = phase_ff;
      init_in  = init_ff;
      fin_in   = fin_ff;
      hs_in    = hs_ff;
      status   = STATUS_OK;
      if (!take) begin
         phase_in = phase_ff;
      end else if (cmd.restart) begin
         phase_in = PH_UNOBSERVED;
         init_in  = DIR_UNKNOWN;
         fin_in   = DIR_UNKNOWN;
         hs_in    = 1'b0;
      end else if (cmd.bad_dir) begin
         status = STATUS_BAD_DIR;
      end else if ((phase_ff == PH_CLOSED) || (phase_ff == PH_RESET)) begin
         phase_in = phase_ff;
      end else if (cmd.ev == EV_RST) begin
         phase_in = PH_RESET;
      end else if (cmd.ev == EV_FIN) begin
         if (phase_ff == PH_FIN) begin
            if (cmd.dir != fin_ff) begin
               phase_in = PH_FIN_BOTH;
            end
         end else if (phase_ff != PH_FIN_BOTH) begin
            phase_in = PH_FIN;
            fin_in   = cmd.dir;
         end
      end else begin
         unique case (phase_ff)
            PH_UNOBSERVED: begin
               if (cmd.ev == EV_SYN) begin
                  phase_in = PH_SYN;
                  init_in  = cmd.dir;
               end else begin
                  phase_in = PH_MIDSTREAM;
               end
            end
            PH_SYN: begin
               if ((cmd.ev == EV_SYN) && (cmd.dir == init_ff)) begin
                  phase_in = PH_SYN;
               end else if ((cmd.ev == EV_SYNACK) && (cmd.dir != init_ff)) begin
                  phase_in = PH_SYNACK;
               end else begin
                  phase_in = PH_MIDSTREAM;
               end
            end
            PH_SYNACK: begin
               if ((cmd.ev == EV_SYNACK) && (cmd.dir != init_ff)) begin
                  phase_in = PH_SYNACK;
               end else if ((cmd.ev == EV_ACK) && (cmd.dir == init_ff)) begin
                  phase_in = PH_ESTABLISHED;
                  hs_in    = 1'b1;
               end else begin
                  phase_in = PH_MIDSTREAM;
               end
            end
            PH_FIN_BOTH: begin
               if ((cmd.ev == EV_ACK) && (cmd.dir == fin_ff)) begin
                  phase_in = PH_CLOSED;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_new.status         = status;
      rsp_new.phase          = phase_in;
      rsp_new.handshake_done = hs_in;
      rsp_new.initiator      = init_in;
      rsp_new.first_fin_side = fin_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (take) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (take && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_UNOBSERVED;
         init_ff   <= DIR_UNKNOWN;
         fin_ff    <= DIR_UNKNOWN;
         hs_ff     <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         init_ff   <= init_in;
         fin_ff    <= fin_in;
         hs_ff     <= hs_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mem_ff[wr_ptr_ff] <= rsp_new;
      end
   end

endmodule

@@ sim/tcpt_phase_checker.sv @@
// Checker for the TCP connection phase tracker: predicts each response
// from the accepted requests and compares it with what the block returns.
// Depends on tcpt_pkg for the request, response, phase and event types.
`timescale 1ns / 1ps

module tcpt_phase_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  tcpt_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  tcpt_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import tcpt_pkg::*;

   phase_type  conn_phase;
   logic [1:0] opener_side;
   logic [1:0] closer_side;
   logic       handshake_seen;

   rsp_type expected_responses[$];
   rsp_type want;
   int      error_total = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic void clear_tracker();
      conn_phase     = PH_UNOBSERVED;
      opener_side    = DIR_UNKNOWN;
      closer_side    = DIR_UNKNOWN;
      handshake_seen = 1'b0;
   endfunction

   function automatic event_type classify_flags(logic [8:0] flags);
      if (flags[FLAG_RST_BIT]) return EV_RST;
      if (flags[FLAG_FIN_BIT]) return EV_FIN;
      if (flags[FLAG_SYN_BIT] && flags[FLAG_ACK_BIT]) return EV_SYNACK;
      if (flags[FLAG_SYN_BIT]) return EV_SYN;
      if (flags[FLAG_ACK_BIT]) return EV_ACK;
      return EV_OTHER;
   endfunction

   function automatic rsp_type track_packet(req_type pkt);
      rsp_type   rsp;
      event_type ev;
      rsp.status = STATUS_OK;
      if (pkt.func == FUNC_RESTART) begin
         clear_tracker();
      end else if (pkt.direction != DIR_A_TO_B && pkt.direction != DIR_B_TO_A) begin
         rsp.status = STATUS_BAD_DIR;
      end else if (conn_phase != PH_CLOSED && conn_phase != PH_RESET) begin
         ev = classify_flags(pkt.flag_bits);
         if (ev == EV_RST) begin
            conn_phase = PH_RESET;
         end else if (ev == EV_FIN) begin
            if (conn_phase == PH_FIN) begin
               if (pkt.direction != closer_side) conn_phase = PH_FIN_BOTH;
            end else if (conn_phase != PH_FIN_BOTH) begin
               conn_phase  = PH_FIN;
               closer_side = pkt.direction;
            end
         end else begin
            case (conn_phase)
               PH_UNOBSERVED: begin
                  if (ev == EV_SYN) begin
                     conn_phase  = PH_SYN;
                     opener_side = pkt.direction;
                  end else begin
                     conn_phase = PH_MIDSTREAM;
                  end
               end
               PH_SYN: begin
                  if (!(ev == EV_SYN && pkt.direction == opener_side))
                     conn_phase = (ev == EV_SYNACK && pkt.direction != opener_side) ?
                                  PH_SYNACK : PH_MIDSTREAM;
               end
               PH_SYNACK: begin
                  if (!(ev == EV_SYNACK && pkt.direction != opener_side)) begin
                     if (ev == EV_ACK && pkt.direction == opener_side) begin
                        conn_phase     = PH_ESTABLISHED;
                        handshake_seen = 1'b1;
                     end else begin
                        conn_phase = PH_MIDSTREAM;
                     end
                  end
               end
               PH_FIN_BOTH: begin
                  if (ev == EV_ACK && pkt.direction == closer_side) conn_phase = PH_CLOSED;
               end
               default: ;
            endcase
         end
      end
      rsp.phase          = conn_phase;
      rsp.handshake_done = handshake_seen;
      rsp.initiator      = opener_side;
      rsp.first_fin_side = closer_side;
      return rsp;
   endfunction

   task automatic compare_field(string field, int expected_value, int actual_value);
      if (expected_value != actual_value) begin
         error_total++;
         if (error_total <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $realtime, field, expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_tracker();
         expected_responses.delete();
      end else begin
         if (!rsp_empty && rsp_pop) begin
            if (expected_responses.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: response with no request outstanding, phase %0d",
                           $realtime, rsp_data.phase);
            end else begin
               want = expected_responses.pop_front();
               compare_field("status", want.status, rsp_data.status);
               compare_field("phase", want.phase, rsp_data.phase);
               compare_field("handshake_done", want.handshake_done,
                             rsp_data.handshake_done);
               compare_field("initiator", want.initiator, rsp_data.initiator);
               compare_field("first_fin_side", want.first_fin_side,
                             rsp_data.first_fin_side);
            end
         end
         if (req_push && !req_full) expected_responses.push_back(track_packet(req_data));
      end
      pending    <= expected_responses.size();
      fail_count <= error_total;
   end

endmodule

@@ sim/testbench.sv @@
// Top of the testbench for the TCP connection phase tracker: clock, reset,
// request and response traffic, and the verdict.
// Depends on tcpt_pkg, the tracker RTL and tcpt_phase_checker.
`timescale 1ns / 1ps

module testbench;
   import tcpt_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_STALL  = 60;

   localparam logic [8:0] FIN_FLAG      = 9'h1 << FLAG_FIN_BIT;
   localparam logic [8:0] SYN_FLAG      = 9'h1 << FLAG_SYN_BIT;
   localparam logic [8:0] RST_FLAG      = 9'h1 << FLAG_RST_BIT;
   localparam logic [8:0] ACK_FLAG      = 9'h1 << FLAG_ACK_BIT;
   localparam logic [8:0] IGNORED_FLAGS = ~(FIN_FLAG | SYN_FLAG | RST_FLAG | ACK_FLAG);

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    rsp_pop  = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int items_sent     = 0;
   int stall_requests = 0;
   int stalls_done    = 0;
   int cycle_count    = 0;
   bit idle_enabled   = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tcp_connection_phase_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   tcpt_phase_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic send_item(logic func, logic [1:0] dir, logic [8:0] flags, bit may_idle);
      req_type pkt;
      pkt.func      = func;
      pkt.direction = dir;
      pkt.flag_bits = flags;
      req_push <= 1'b1;
      req_data <= pkt;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (may_idle && idle_enabled && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_packet(logic [1:0] dir, logic [8:0] base);
      if ($urandom_range(0, 11) == 0)
         send_item(($urandom_range(0, 5) == 0) ? FUNC_RESTART : FUNC_OBSERVE,
                   2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), 1'b1);
      else
         send_item(FUNC_OBSERVE, dir, base | (9'($urandom) & IGNORED_FLAGS), 1'b1);
   endtask

   task automatic send_noise(int count, bit may_idle);
      repeat (count)
         send_item(($urandom_range(0, 9) == 0) ? FUNC_RESTART : FUNC_OBSERVE,
                   2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), may_idle);
   endtask

   // One connection, with an optional restart first, through handshake, data and a FIN teardown or a reset.
   task automatic send_flow();
      logic [1:0] opener;
      logic [1:0] answerer;
      logic [1:0] closer;
      logic [1:0] other;
      opener   = 2'($urandom_range(1, 2));
      answerer = 2'd3 - opener;
      closer   = 2'($urandom_range(1, 2));
      other    = 2'd3 - closer;
      if ($urandom_range(0, 4) != 0)
         send_item(FUNC_RESTART, 2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)), 1'b1);
      send_packet(opener, SYN_FLAG);
      if ($urandom_range(0, 3) == 0) send_packet(opener, SYN_FLAG);
      send_packet(answerer, SYN_FLAG | ACK_FLAG);
      if ($urandom_range(0, 3) == 0) send_packet(answerer, SYN_FLAG | ACK_FLAG);
      send_packet(opener, ACK_FLAG);
      repeat ($urandom_range(0, 5))
         send_packet(2'($urandom_range(1, 2)), $urandom_range(0, 1) ? ACK_FLAG : 9'h0);
      if ($urandom_range(0, 7) == 0) begin
         send_packet(2'($urandom_range(1, 2)), RST_FLAG);
         send_packet(2'($urandom_range(1, 2)), ACK_FLAG);
      end else begin
         send_packet(closer, FIN_FLAG | ACK_FLAG);
         if ($urandom_range(0, 2) == 0) send_packet(closer, FIN_FLAG);
         send_packet(other, FIN_FLAG | ACK_FLAG);
         if ($urandom_range(0, 2) == 0) send_packet(2'($urandom_range(1, 2)), FIN_FLAG);
         if ($urandom_range(0, 2) == 0) send_packet(other, ACK_FLAG);
         send_packet(closer, ACK_FLAG);
         if ($urandom_range(0, 1) == 0)
            send_packet(2'($urandom_range(1, 2)), 9'($urandom_range(0, 511)));
      end
   endtask

   task automatic run_traffic(int upto);
      while (items_sent < upto) begin
         if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6), 1'b1);
         else send_flow();
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (stall_requests != stalls_done) begin
            stalls_done = stall_requests;
            rsp_pop <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else if (idle_enabled && $urandom_range(0, 11) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(FUNC_RESTART, 2'd3, 9'h1FF, 1'b1);
      send_item(FUNC_OBSERVE, DIR_UNKNOWN, SYN_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, 2'd3, 9'h000, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, SYN_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, SYN_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, SYN_FLAG | ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, SYN_FLAG | ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, 9'h000, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_UNKNOWN, FIN_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, FIN_FLAG | ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, FIN_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, FIN_FLAG | ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, FIN_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, ACK_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, RST_FLAG, 1'b1);
      send_item(FUNC_RESTART, DIR_UNKNOWN, 9'h000, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, 9'h1FF, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, SYN_FLAG, 1'b1);
      send_item(FUNC_RESTART, DIR_A_TO_B, SYN_FLAG, 1'b1);
      send_item(FUNC_OBSERVE, DIR_A_TO_B, SYN_FLAG | FIN_FLAG, 1'b1);
      send_item(FUNC_RESTART, DIR_B_TO_A, 9'h000, 1'b1);
      send_item(FUNC_OBSERVE, DIR_B_TO_A, IGNORED_FLAGS, 1'b1);
      wait_idle();

      run_traffic(500);

      // Hold the response side off while requests keep coming, so the
      // queues fill and req_full must push back.
      stall_requests++;
      send_noise(40, 1'b0);
      wait_idle();

      run_traffic(1000);
      idle_enabled = 1'b0;
      run_traffic(1220);
      wait_idle();
      repeat (10) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
